// File: rtl/core/gdd_pkg.sv
// Package for the Gregorian date difference block: field widths, constants,
// and the month length and month offset tables.
// No dependencies.
package gdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;
    localparam int DNUM_W  = 23;   // day number of a year up to 16383
    localparam int Q4_W    = YEAR_W - 2;
    localparam int RECIP_W = 11;
    localparam int PROD_W  = Q4_W + RECIP_W;
    localparam int Q100_W  = PROD_W - 15;

    localparam logic [YEAR_W-1:0]  YEAR_MIN    = 14'd1582;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 22'd4194303;
    // floor(x / 25) = (x * 1311) >> 15 for every x below 4096
    localparam logic [RECIP_W-1:0] RECIP_25    = 11'd1311;
    localparam int                 RECIP_SHIFT = 15;
    localparam logic [8:0]         DAYS_YEAR   = 9'd365;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_MAY = 4'd5;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_JUL = 4'd7;
    localparam logic [MONTH_W-1:0] MONTH_AUG = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_OCT = 4'd10;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Length of a month; zero for codes that are not months.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL,
            MONTH_AUG, MONTH_OCT, MONTH_DEC: len = 5'd31;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days from March 1 to the first of the month, in a March-based year.
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [8:0] ofs;
        case (m)
            MONTH_MAR: ofs = 9'd0;
            MONTH_APR: ofs = 9'd31;
            MONTH_MAY: ofs = 9'd61;
            MONTH_JUN: ofs = 9'd92;
            MONTH_JUL: ofs = 9'd122;
            MONTH_AUG: ofs = 9'd153;
            MONTH_SEP: ofs = 9'd184;
            MONTH_OCT: ofs = 9'd214;
            MONTH_NOV: ofs = 9'd245;
            MONTH_DEC: ofs = 9'd275;
            MONTH_JAN: ofs = 9'd306;
            MONTH_FEB: ofs = 9'd337;
            default:   ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

// File: rtl/core/gregorian_date_difference.sv
// Gregorian date difference: absolute day count between two dates.
// A pair transferred at a rising edge passes the stage 1, stage 2 and output registers
// and gives its result with done high; throughput one pair per cycle, busy stays low.
// Rate is set by the three-stage pipeline: reciprocal multiply, day number, subtract.
// Reset (rst_n low, asynchronous) clears the stage valid bits and done.
// The receiver cannot stall; each result stands for exactly one cycle.
// Depends on gdd_pkg.
module gregorian_date_difference
    import gdd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [DAY_W-1:0]   day_first,
    input  logic [MONTH_W-1:0] month_first,
    input  logic [YEAR_W-1:0]  year_first,
    input  logic [DAY_W-1:0]   day_second,
    input  logic [MONTH_W-1:0] month_second,
    input  logic [YEAR_W-1:0]  year_second,
    output logic               done,
    output logic [COUNT_W-1:0] day_count,
    output logic               dates_valid
);

    typedef struct packed {
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] m;
        logic [YEAR_W-1:0]  y;
        logic [YEAR_W-1:0]  yy;     // March-based year
        logic [PROD_W-1:0]  p_y;    // (y >> 2) * RECIP_25
        logic [PROD_W-1:0]  p_yy;   // (yy >> 2) * RECIP_25
    } s1_lane_t;

    typedef struct packed {
        logic              ok;
        logic [DNUM_W-1:0] dnum;
    } s2_lane_t;

    // the pipeline never stalls
    assign busy = 1'b0;

    logic [DAY_W-1:0]   in_d [2];
    logic [MONTH_W-1:0] in_m [2];
    logic [YEAR_W-1:0]  in_y [2];

    assign in_d[0] = day_first;
    assign in_m[0] = month_first;
    assign in_y[0] = year_first;
    assign in_d[1] = day_second;
    assign in_m[1] = month_second;
    assign in_y[1] = year_second;

    // ---------------- stage 1: year shift and reciprocal multiply
    s1_lane_t s1_next [2];
    s1_lane_t s1_reg  [2];
    logic     s1_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            s1_next[i].d  = in_d[i];
            s1_next[i].m  = in_m[i];
            s1_next[i].y  = in_y[i];
            s1_next[i].yy = (in_m[i] <= MONTH_FEB) ? in_y[i] - 14'd1 : in_y[i];
            s1_next[i].p_y  = PROD_W'(in_y[i][YEAR_W-1:2]) * PROD_W'(RECIP_25);
            s1_next[i].p_yy = PROD_W'(s1_next[i].yy[YEAR_W-1:2]) * PROD_W'(RECIP_25);
        end
    end

    // ---------------- stage 2: leap test, date check, day number
    s2_lane_t s2_next [2];
    s2_lane_t s2_reg  [2];
    logic     s2_valid_reg;

    always_comb
    begin
        logic [Q100_W-1:0] q100_y;
        logic [Q4_W-1:0]   rem25;
        logic              div100;
        logic              div400;
        logic              leap;
        logic [DAY_W-1:0]  len;
        logic [Q100_W-1:0] q100_yy;
        logic [Q4_W-1:0]   q4_yy;
        for (int i = 0; i < 2; i++)
        begin
            q100_y = s1_reg[i].p_y[PROD_W-1:RECIP_SHIFT];
            rem25  = s1_reg[i].y[YEAR_W-1:2] - (Q4_W'(q100_y) * Q4_W'(8'd25));
            div100 = (s1_reg[i].y[1:0] == 2'd0) && (rem25 == '0);
            div400 = div100 && (q100_y[1:0] == 2'd0);
            leap   = ((s1_reg[i].y[1:0] == 2'd0) && !div100) || div400;
            len    = month_len(s1_reg[i].m, leap);

            s2_next[i].ok = (s1_reg[i].y >= YEAR_MIN) && (len != '0)
                            && (s1_reg[i].d != '0) && (s1_reg[i].d <= len);

            q100_yy = s1_reg[i].p_yy[PROD_W-1:RECIP_SHIFT];
            q4_yy   = s1_reg[i].yy[YEAR_W-1:2];
            s2_next[i].dnum = DNUM_W'(s1_reg[i].yy) * DNUM_W'(DAYS_YEAR)
                            + DNUM_W'(q4_yy) - DNUM_W'(q100_yy)
                            + DNUM_W'(q100_yy[Q100_W-1:2])
                            + DNUM_W'(month_offset(s1_reg[i].m))
                            + DNUM_W'(s1_reg[i].d);
        end
    end

    // ---------------- stage 3: absolute difference and saturation
    logic               both_ok;
    logic [DNUM_W-1:0]  diff;
    logic [COUNT_W-1:0] count_next;
    logic               valid_next;
    logic               done_reg;
    logic [COUNT_W-1:0] day_count_reg;
    logic               dates_valid_reg;

    always_comb
    begin
        both_ok = s2_reg[0].ok && s2_reg[1].ok;
        diff = (s2_reg[0].dnum >= s2_reg[1].dnum) ? s2_reg[0].dnum - s2_reg[1].dnum
                                                  : s2_reg[1].dnum - s2_reg[0].dnum;
        if (!both_ok)
            count_next = '0;
        else if (diff > DNUM_W'(COUNT_MAX))
            count_next = COUNT_MAX;
        else
            count_next = diff[COUNT_W-1:0];
        valid_next = s2_valid_reg && both_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
            dates_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg    <= start && !busy;
            s2_valid_reg    <= s1_valid_reg;
            done_reg        <= s2_valid_reg;
            dates_valid_reg <= valid_next;
        end
    end

    // payload: advance every cycle, only the valid bits matter
    always_ff @(posedge clk)
    begin
        s1_reg        <= s1_next;
        s2_reg        <= s2_next;
        day_count_reg <= count_next;
    end

    assign done        = done_reg;
    assign day_count   = day_count_reg;
    assign dates_valid = dates_valid_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("transfer did not produce a result after three cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_valid_reg, 2))
        else $error("result without a matching transfer");

    a_valid_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        dates_valid |-> done)
        else $error("dates_valid raised outside a result cycle");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !dates_valid) |-> (day_count == '0))
        else $error("invalid dates gave a nonzero count");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (day_count <= COUNT_MAX))
        else $error("day count above saturation limit");

endmodule
